### src/pit_pkg.sv
// Shared types and constants for the point-in-triangle test pipeline.
`timescale 1ns / 1ps

package pit_pkg;

	// Default coordinate width (signed Q8.8 at 16 bits)
	localparam int COORD_BITS_DEF = 16;

	// Coordinates per input item: point plus three vertices, three axes each
	localparam int NUM_COORDS = 12;

	// Output tdata width: one result bit padded to a byte
	localparam int OUT_TDATA_W = 8;

	// Registers from input to output, each holding at most one transaction
	localparam int PIPE_DEPTH = 7;

	// Load enables for the cross-product stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} cross_en_t;

	// Load enables for the dot-product stages
	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
	} dot_en_t;

endpackage

### src/pit_cross.sv
// Edge vectors and the two cross products of one same-side check (stages 1 to 3).
`timescale 1ns / 1ps

module pit_cross #(
	parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF,
	localparam int CW = 2 * COORD_BITS + 3
) (
	input  logic                         clk,
	input  pit_pkg::cross_en_t           en,
	input  logic signed [COORD_BITS-1:0] p [3],
	input  logic signed [COORD_BITS-1:0] q [3],
	input  logic signed [COORD_BITS-1:0] s [3],
	input  logic signed [COORD_BITS-1:0] e [3],
	output logic signed [CW-1:0]         u [3],
	output logic signed [CW-1:0]         w [3]
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;

	logic signed [DW-1:0] edge_s1 [3];
	logic signed [DW-1:0] vp_s1   [3];
	logic signed [DW-1:0] vq_s1   [3];

	logic signed [PW-1:0] pu_a_s2 [3];
	logic signed [PW-1:0] pu_b_s2 [3];
	logic signed [PW-1:0] pw_a_s2 [3];
	logic signed [PW-1:0] pw_b_s2 [3];

	logic signed [CW-1:0] u_s3 [3];
	logic signed [CW-1:0] w_s3 [3];

	for (genvar i = 0; i < 3; i++) begin : g_comp
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;

		always_ff @(posedge clk) begin
			if (en.s1) begin
				edge_s1[i] <= $signed({e[i][COORD_BITS-1], e[i]}) -
					$signed({s[i][COORD_BITS-1], s[i]});
				vp_s1[i] <= $signed({p[i][COORD_BITS-1], p[i]}) -
					$signed({s[i][COORD_BITS-1], s[i]});
				vq_s1[i] <= $signed({q[i][COORD_BITS-1], q[i]}) -
					$signed({s[i][COORD_BITS-1], s[i]});
			end
		end

		// Component i of edge x v: edge[i+1]*v[i+2] - edge[i+2]*v[i+1]
		always_ff @(posedge clk) begin
			if (en.s2) begin
				pu_a_s2[i] <= edge_s1[I1] * vp_s1[I2];
				pu_b_s2[i] <= edge_s1[I2] * vp_s1[I1];
				pw_a_s2[i] <= edge_s1[I1] * vq_s1[I2];
				pw_b_s2[i] <= edge_s1[I2] * vq_s1[I1];
			end
		end

		always_ff @(posedge clk) begin
			if (en.s3) begin
				u_s3[i] <= CW'(pu_a_s2[i]) - CW'(pu_b_s2[i]);
				w_s3[i] <= CW'(pw_a_s2[i]) - CW'(pw_b_s2[i]);
			end
		end

		assign u[i] = u_s3[i];
		assign w[i] = w_s3[i];
	end

endmodule

### src/pit_dot.sv
// Sign of the exact dot product of two cross products, split multiply (stages 4 to 6).
`timescale 1ns / 1ps

module pit_dot #(
	parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF,
	localparam int CW = 2 * COORD_BITS + 3
) (
	input  logic                 clk,
	input  pit_pkg::dot_en_t     en,
	input  logic signed [CW-1:0] u [3],
	input  logic signed [CW-1:0] w [3],
	output logic                 nonneg
);

	// Each operand splits into a signed high part and an unsigned low part
	localparam int K  = (CW + 1) / 2;
	localparam int HW = CW - K;
	localparam int TW = 2 * CW;
	localparam int SW = TW + 2;

	logic signed [2*HW-1:0]  hh_s4 [3];
	logic signed [HW+K:0]    hl_s4 [3];
	logic signed [HW+K:0]    lh_s4 [3];
	logic signed [2*K+1:0]   ll_s4 [3];
	logic signed [TW-1:0]    term_s5 [3];
	logic                    nonneg_s6;
	logic signed [SW-1:0]    dot_sum;

	for (genvar i = 0; i < 3; i++) begin : g_term
		logic signed [HW-1:0] u_hi, w_hi;
		logic signed [K:0]    u_lo, w_lo;

		assign u_hi = $signed(u[i][CW-1:K]);
		assign w_hi = $signed(w[i][CW-1:K]);
		assign u_lo = $signed({1'b0, u[i][K-1:0]});
		assign w_lo = $signed({1'b0, w[i][K-1:0]});

		always_ff @(posedge clk) begin
			if (en.s4) begin
				hh_s4[i] <= u_hi * w_hi;
				hl_s4[i] <= u_hi * w_lo;
				lh_s4[i] <= u_lo * w_hi;
				ll_s4[i] <= u_lo * w_lo;
			end
		end

		// Recombine; intermediate wrap cancels since the full product fits TW
		always_ff @(posedge clk) begin
			if (en.s5) begin
				term_s5[i] <= (TW'(hh_s4[i]) <<< (2 * K)) +
					((TW'(hl_s4[i]) + TW'(lh_s4[i])) <<< K) + TW'(ll_s4[i]);
			end
		end
	end

	assign dot_sum = SW'(term_s5[0]) + SW'(term_s5[1]) + SW'(term_s5[2]);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			nonneg_s6 <= ~dot_sum[SW-1];
		end
	end

	assign nonneg = nonneg_s6;

endmodule

### src/point_in_triangle_test_core.sv
// Top level: same-side point-in-triangle test, fully pipelined stream block.
// Path from input transaction to result on m_axis: stage 1 loads at the
// accepting edge, then five more arithmetic stages and the output register.
// Throughput: one transaction per cycle unless m_axis stalls; each stage loads
// when it is empty or its successor moves, so bubbles close up under output stall.
// Reset clears the valid bits of every stage; payload registers are not reset.
`timescale 1ns / 1ps

module point_in_triangle_test_core #(
	parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF,
	localparam int IN_W = ((pit_pkg::NUM_COORDS * COORD_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz (COORD_BITS each), zero pad
	input  logic [IN_W-1:0]                 s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// inside_res, zero pad
	output logic [pit_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int CW = 2 * COORD_BITS + 3;

	logic signed [COORD_BITS-1:0] p_v [3];
	logic signed [COORD_BITS-1:0] a_v [3];
	logic signed [COORD_BITS-1:0] b_v [3];
	logic signed [COORD_BITS-1:0] c_v [3];

	logic [6:1] vld_s;
	logic [6:1] rdy_s;
	logic       rdy_out;
	logic       out_vld_q;
	logic [pit_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic [2:0] side_ok;

	pit_pkg::cross_en_t cross_en;
	pit_pkg::dot_en_t   dot_en;

	for (genvar j = 0; j < 3; j++) begin : g_unpack
		assign p_v[j] = s_axis_tdata[j * COORD_BITS +: COORD_BITS];
		assign a_v[j] = s_axis_tdata[(3 + j) * COORD_BITS +: COORD_BITS];
		assign b_v[j] = s_axis_tdata[(6 + j) * COORD_BITS +: COORD_BITS];
		assign c_v[j] = s_axis_tdata[(9 + j) * COORD_BITS +: COORD_BITS];
	end

	// Ready ripples back: a stage can load when empty or when it drains
	assign rdy_out = ~out_vld_q | m_axis_tready;
	assign rdy_s[6] = ~vld_s[6] | rdy_out;
	for (genvar k = 1; k < 6; k++) begin : g_rdy
		assign rdy_s[k] = ~vld_s[k] | rdy_s[k+1];
	end
	assign s_axis_tready = rdy_s[1];

	assign cross_en = '{s1: rdy_s[1], s2: rdy_s[2], s3: rdy_s[3]};
	assign dot_en   = '{s4: rdy_s[4], s5: rdy_s[5], s6: rdy_s[6]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy_s[1]) vld_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= 6; k++) begin
				if (rdy_s[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Side 0: p vs a about b-c; side 1: p vs b about a-c; side 2: p vs c about a-b
	for (genvar k = 0; k < 3; k++) begin : g_side
		logic signed [COORD_BITS-1:0] s_v [3];
		logic signed [COORD_BITS-1:0] e_v [3];
		logic signed [COORD_BITS-1:0] q_v [3];
		logic signed [CW-1:0]         u_v [3];
		logic signed [CW-1:0]         w_v [3];

		for (genvar j = 0; j < 3; j++) begin : g_sel
			if (k == 0) begin : g_k0
				assign s_v[j] = b_v[j];
				assign e_v[j] = c_v[j];
				assign q_v[j] = a_v[j];
			end else if (k == 1) begin : g_k1
				assign s_v[j] = a_v[j];
				assign e_v[j] = c_v[j];
				assign q_v[j] = b_v[j];
			end else begin : g_k2
				assign s_v[j] = a_v[j];
				assign e_v[j] = b_v[j];
				assign q_v[j] = c_v[j];
			end
		end

		pit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
			.clk (clk),
			.en  (cross_en),
			.p   (p_v),
			.q   (q_v),
			.s   (s_v),
			.e   (e_v),
			.u   (u_v),
			.w   (w_v)
		);

		pit_dot #(.COORD_BITS(COORD_BITS)) u_dot (
			.clk    (clk),
			.en     (dot_en),
			.u      (u_v),
			.w      (w_v),
			.nonneg (side_ok[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rdy_out) begin
			out_vld_q <= vld_s[6];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			out_data_q <= pit_pkg::OUT_TDATA_W'(&side_ok);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### src/pit_checker.sv
// Port-level checks for the point-in-triangle core, bound to the top level.
`timescale 1ns / 1ps

module pit_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [pit_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [3:0] inflight_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = s_axis_tvalid & s_axis_tready;
	assign out_xfer = m_axis_tvalid & m_axis_tready;

	// Track transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 4'(in_xfer) - 4'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 4'd0)
		else $error("result with no transaction in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'(pit_pkg::PIPE_DEPTH))
		else $error("more transactions in flight than pipeline stages");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input stalled while the output drains");

endmodule

bind point_in_triangle_test_core pit_checker u_pit_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### tb/tb.sv
// Self-checking testbench for point_in_triangle_test_core with a local same-side predictor.
`timescale 1ns / 1ps

module tb;

	localparam int CB    = pit_pkg::COORD_BITS_DEF;
	localparam int NC    = pit_pkg::NUM_COORDS;
	localparam int IN_W  = ((NC * CB + 7) / 8) * 8;
	localparam int OUT_W = pit_pkg::OUT_TDATA_W;
	localparam int ITEMS_PER_PHASE = 534;

	typedef logic signed [CB-1:0]  coord_t;
	typedef logic signed [127:0]   wide_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct {
		point_t p;
		point_t a;
		point_t b;
		point_t c;
	} tri_query_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	tri_query_t pend_q[$];
	bit         inside_q[$];
	tri_query_t cur_query;
	int         tx_idle_pct = 30;
	int         rx_idle_pct = 64;
	int         n_err = 0;

	point_in_triangle_test_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// True when p and q sit on the same side of (or on) the line s-e.
	function automatic bit same_side(point_t p, point_t q, point_t s, point_t e);
		wide_t ex, ey, ez, px, py, pz, qx, qy, qz;
		wide_t ux, uy, uz, wx, wy, wz, dot;
		ex = wide_t'(e.x) - wide_t'(s.x);
		ey = wide_t'(e.y) - wide_t'(s.y);
		ez = wide_t'(e.z) - wide_t'(s.z);
		px = wide_t'(p.x) - wide_t'(s.x);
		py = wide_t'(p.y) - wide_t'(s.y);
		pz = wide_t'(p.z) - wide_t'(s.z);
		qx = wide_t'(q.x) - wide_t'(s.x);
		qy = wide_t'(q.y) - wide_t'(s.y);
		qz = wide_t'(q.z) - wide_t'(s.z);
		ux = ey * pz - ez * py;
		uy = ez * px - ex * pz;
		uz = ex * py - ey * px;
		wx = ey * qz - ez * qy;
		wy = ez * qx - ex * qz;
		wz = ex * qy - ey * qx;
		dot = ux * wx + uy * wy + uz * wz;
		return !dot[127];
	endfunction

	function automatic bit in_triangle(tri_query_t t);
		return same_side(t.p, t.a, t.b, t.c) && same_side(t.p, t.b, t.a, t.c) &&
			same_side(t.p, t.c, t.a, t.b);
	endfunction

	function automatic logic [IN_W-1:0] pack_query(tri_query_t t);
		coord_t f[NC] = '{t.p.x, t.p.y, t.p.z, t.a.x, t.a.y, t.a.z,
			t.b.x, t.b.y, t.b.z, t.c.x, t.c.y, t.c.z};
		logic [IN_W-1:0] d;
		d = '0;
		for (int i = 0; i < NC; i++) d[i*CB +: CB] = f[i];
		return d;
	endfunction

	function automatic point_t mkp(int x, int y, int z);
		point_t r;
		r.x = coord_t'(x);
		r.y = coord_t'(y);
		r.z = coord_t'(z);
		return r;
	endfunction

	function automatic tri_query_t mkq(point_t p, point_t a, point_t b, point_t c);
		tri_query_t t;
		t.p = p;
		t.a = a;
		t.b = b;
		t.c = c;
		return t;
	endfunction

	function automatic int rnd(int lim);
		return int'($urandom_range(2 * lim)) - lim;
	endfunction

	function automatic point_t rnd_pt(int lim);
		return mkp(rnd(lim), rnd(lim), rnd(lim));
	endfunction

	function automatic int rnd_edge_val();
		int sel;
		sel = $urandom_range(4);
		case (sel)
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic tri_query_t gen_query();
		tri_query_t t;
		point_t d;
		int kind, z0, k;
		kind = $urandom_range(99);
		if (kind < 20) begin
			t = mkq(mkp($urandom, $urandom, $urandom), mkp($urandom, $urandom, $urandom),
				mkp($urandom, $urandom, $urandom), mkp($urandom, $urandom, $urandom));
		end else if (kind < 60 || kind >= 85 && kind < 92) begin
			// flat triangle with the point in the same square region; sometimes lift it off
			z0 = rnd(30000);
			t.a = mkp(rnd(2000), rnd(2000), z0);
			t.b = mkp(rnd(2000), rnd(2000), z0);
			t.c = mkp(rnd(2000), rnd(2000), z0);
			t.p = mkp(rnd(2000), rnd(2000), z0);
			if (kind >= 60) t.p.z = coord_t'(rnd(32767));
		end else if (kind < 75) begin
			// point at an edge midpoint or on a vertex
			t.a = rnd_pt(8000);
			t.c = rnd_pt(8000);
			d = rnd_pt(4000);
			t.b = mkp(t.a.x + 2 * d.x, t.a.y + 2 * d.y, t.a.z + 2 * d.z);
			t.p = ($urandom_range(3) == 0) ? t.b :
				mkp(t.a.x + d.x, t.a.y + d.y, t.a.z + d.z);
		end else if (kind < 85) begin
			// collinear or coincident vertices
			t.a = rnd_pt(4000);
			t.b = ($urandom_range(4) == 0) ? t.a : rnd_pt(4000);
			k = int'($urandom_range(3)) - 1;
			t.c = mkp(t.a.x + k * (t.b.x - t.a.x), t.a.y + k * (t.b.y - t.a.y),
				t.a.z + k * (t.b.z - t.a.z));
			t.p = mkp($urandom, $urandom, $urandom);
		end else begin
			t.p = mkp(rnd_edge_val(), rnd_edge_val(), rnd_edge_val());
			t.a = mkp(rnd_edge_val(), rnd_edge_val(), rnd_edge_val());
			t.b = mkp(rnd_edge_val(), rnd_edge_val(), rnd_edge_val());
			t.c = mkp(rnd_edge_val(), rnd_edge_val(), rnd_edge_val());
		end
		return t;
	endfunction

	// Present the next pending query; record its expectation on the transaction.
	always @(posedge clk) begin : drive_proc
		logic take;
		take = s_axis_tvalid && s_axis_tready;
		if (take) inside_q.push_back(in_triangle(cur_query));
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || take) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				cur_query = pend_q.pop_front();
				s_axis_tdata <= pack_query(cur_query);
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_proc
		logic exp_bit;
		logic [OUT_W-1:0] exp_data;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (inside_q.size() == 0) begin
					n_err++;
					$display("%0t: unexpected result, expected none, actual tdata=%h",
						$time, m_axis_tdata);
				end else begin
					exp_bit = inside_q.pop_front();
					exp_data = {{(OUT_W-1){1'b0}}, exp_bit};
					if (m_axis_tdata !== exp_data) begin
						n_err++;
						$display("%0t: inside_res mismatch, expected tdata=%h, actual tdata=%h",
							$time, exp_data, m_axis_tdata);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		point_t ta, tb_, tc;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners
		pend_q.push_back(mkq(mkp(0, 0, 0), mkp(0, 0, 0), mkp(0, 0, 0), mkp(0, 0, 0)));
		pend_q.push_back(mkq(mkp(32767, 32767, 32767), mkp(32767, 32767, 32767),
			mkp(32767, 32767, 32767), mkp(32767, 32767, 32767)));
		pend_q.push_back(mkq(mkp(-32768, -32768, -32768), mkp(-32768, -32768, -32768),
			mkp(-32768, -32768, -32768), mkp(-32768, -32768, -32768)));
		pend_q.push_back(mkq(mkp(-32768, 32767, -32768), mkp(32767, -32768, 32767),
			mkp(-32768, -32768, 32767), mkp(32767, 32767, -32768)));
		pend_q.push_back(mkq(mkp(-1, 1, -1), mkp(1, -1, 1), mkp(-1, -1, 1), mkp(1, 1, -1)));
		ta = mkp(-32768, -32768, 0);
		tb_ = mkp(32767, -32768, 0);
		tc = mkp(0, 32767, 0);
		pend_q.push_back(mkq(mkp(0, 0, 0), ta, tb_, tc));
		pend_q.push_back(mkq(mkp(32767, 32767, 0), ta, tb_, tc));
		pend_q.push_back(mkq(mkp(-32768, 32767, 32767), ta, tb_, tc));
		// right triangle with legs of 1024: vertex, edges, interior, exterior, off the plane
		ta = mkp(0, 0, 0);
		tb_ = mkp(1024, 0, 0);
		tc = mkp(0, 1024, 0);
		pend_q.push_back(mkq(mkp(0, 0, 0), ta, tb_, tc));
		pend_q.push_back(mkq(mkp(512, 0, 0), ta, tb_, tc));
		pend_q.push_back(mkq(mkp(512, 512, 0), ta, tb_, tc));
		pend_q.push_back(mkq(mkp(256, 256, 0), ta, tb_, tc));
		pend_q.push_back(mkq(mkp(1024, 1024, 0), ta, tb_, tc));
		pend_q.push_back(mkq(mkp(-1, -1, 0), ta, tb_, tc));
		pend_q.push_back(mkq(mkp(256, 256, 20000), ta, tb_, tc));
		pend_q.push_back(mkq(mkp(2000, 2000, -20000), ta, tb_, tc));
		// degenerate triangles
		pend_q.push_back(mkq(mkp(32767, -32768, 100), mkp(0, 0, 0), mkp(256, 256, 256),
			mkp(512, 512, 512)));
		pend_q.push_back(mkq(mkp(-5000, 6000, 7000), mkp(100, -200, 300),
			mkp(100, -200, 300), mkp(100, -200, 300)));
		pend_q.push_back(mkq(mkp(4000, 4000, 4000), mkp(100, -200, 300),
			mkp(100, -200, 300), mkp(-900, 800, 0)));
		// tilted and negative-space triangles
		pend_q.push_back(mkq(mkp(85, 85, 86), mkp(256, 0, 0), mkp(0, 256, 0), mkp(0, 0, 256)));
		pend_q.push_back(mkq(mkp(-600, -700, -500), mkp(-1000, -1000, -500),
			mkp(-200, -1000, -500), mkp(-600, -100, -500)));

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 30; rx_idle_pct = 64; end
				1: begin tx_idle_pct = 64; rx_idle_pct = 30; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) pend_q.push_back(gen_query());
			// hold the next phase until the pipeline has drained
			while (pend_q.size() != 0 || s_axis_tvalid) @(negedge clk);
			while (inside_q.size() != 0) @(negedge clk);
		end

		repeat (4 * pit_pkg::PIPE_DEPTH) @(negedge clk);
		if (n_err == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
